// ----- rtl/crp_pkg.sv -----
// ----------------------------------------------------------------------------
// crp_pkg
// Shared constants and elaboration-time helpers for the Corey relperm row
// evaluator: fixed-point format, pipeline latencies and the exp2 root factors.
// ----------------------------------------------------------------------------
package crp_pkg;

    // Q0.16 saturations and results, one extra bit to hold exactly one
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = FRAC_BITS + 1;
    localparam logic [VAL_W-1:0] ONE = VAL_W'(1 << FRAC_BITS);

    // Largest row count accepted by the setup check
    localparam int MAX_ROWS = 1024;

    // log2(e) in Q.24
    localparam logic [24:0] L2E_Q24 = 25'd24204406;

    // Pipeline depth of the log and exp units (entry stage, 30 steps, exit stage)
    localparam int LOG_LAT = 32;
    localparam int EXP_LAT = 32;

    // Truncated integer square root, evaluated at elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = '0;
        b   = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (b > rem) begin
                b = b >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (b != 0) begin
                if (rem >= res + b) begin
                    rem = rem - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // Factor 2^(-2^-k) in Q.30, built by the repeated truncated square root
    function automatic logic [29:0] root_factor(input int k);
        logic [63:0] r;
        r = isqrt64(64'd1 << 59);
        for (int j = 1; j < k; j++) begin
            r = isqrt64(r << 30);
        end
        return r[29:0];
    endfunction

endpackage

// ----- rtl/corey_relperm_table_row_top.sv -----
// ----------------------------------------------------------------------------
// corey_relperm_table_row_top
// Corey water-oil relative permeability table row evaluator. One row index
// in, one row out: saturation, both relperms, capillary term and flags.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+-------------------------------
//   input   | in        | i_valid / o_stall  | i_row_index
//   output  | out       | o_valid / i_stall  | saturation, relperms, pc, flags
//   config  | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One word per cycle sustained while the output is not stalled; the path runs
// through the chain of dividers (17 stages each), the log unit and the exp unit.
// Synchronous active-low reset clears valid bits and loads register defaults.
// A stall on the output holds the whole pipeline; o_stall is raised while
// the output word waits.
// ----------------------------------------------------------------------------
module corey_relperm_table_row_top
    import crp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [9:0]       i_row_index,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [VAL_W-1:0] o_water_saturation,
    output logic [VAL_W-1:0] o_water_relperm,
    output logic [VAL_W-1:0] o_oil_relperm,
    output logic [VAL_W-1:0] o_capillary_pressure,
    output logic             o_last_row,
    output logic             o_bad_setup,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [16:0]      i_cfg_data
);

    localparam logic [2:0] CFG_CONNATE_WATER  = 3'd0;
    localparam logic [2:0] CFG_CONNATE_OIL    = 3'd1;
    localparam logic [2:0] CFG_WATER_EXPONENT = 3'd2;
    localparam logic [2:0] CFG_OIL_EXPONENT   = 3'd3;
    localparam logic [2:0] CFG_WATER_SCALE    = 3'd4;
    localparam logic [2:0] CFG_OIL_SCALE      = 3'd5;
    localparam logic [2:0] CFG_PRESSURE_GAIN  = 3'd6;
    localparam logic [2:0] CFG_ROW_COUNT      = 3'd7;

    localparam int DIV_LAT = VAL_W;

    typedef struct packed {
        logic valid;
        logic bad;
        logic last;
    } t_band;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_connate_water;
    logic [15:0] r_connate_oil;
    logic [15:0] r_water_exponent;
    logic [15:0] r_oil_exponent;
    logic [16:0] r_water_scale;
    logic [16:0] r_oil_scale;
    logic [15:0] r_pressure_gain;
    logic [10:0] r_row_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_connate_water  <= 16'd6554;
            r_connate_oil    <= 16'd6554;
            r_water_exponent <= 16'd8192;
            r_oil_exponent   <= 16'd8192;
            r_water_scale    <= 17'd65536;
            r_oil_scale      <= 17'd65536;
            r_pressure_gain  <= 16'd256;
            r_row_count      <= 11'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CONNATE_WATER:  r_connate_water  <= i_cfg_data[15:0];
                CFG_CONNATE_OIL:    r_connate_oil    <= i_cfg_data[15:0];
                CFG_WATER_EXPONENT: r_water_exponent <= i_cfg_data[15:0];
                CFG_OIL_EXPONENT:   r_oil_exponent   <= i_cfg_data[15:0];
                CFG_WATER_SCALE:    r_water_scale    <= i_cfg_data;
                CFG_OIL_SCALE:      r_oil_scale      <= i_cfg_data;
                CFG_PRESSURE_GAIN:  r_pressure_gain  <= i_cfg_data[15:0];
                CFG_ROW_COUNT:      r_row_count      <= i_cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    // global advance: everything moves unless the output word is held
    logic adv;
    logic r_out_valid;

    assign o_stall = r_out_valid & i_stall;
    assign adv     = ~o_stall;

    // span of usable saturation
    logic [VAL_W-1:0] denom;
    assign denom = ONE - VAL_W'(r_connate_water) - VAL_W'(r_connate_oil);

    // ------------------------------------------------------------------
    // stage 1: setup check and saturation step numerator
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] cw_co;
    logic [VAL_W-1:0] one_m_cw;
    logic [26:0]      prod_sw;
    logic             n_bad;
    logic             n_last;
    t_band            r_s1_band;
    logic [28:0]      r_s1_num;
    logic [11:0]      r_s1_den;

    assign cw_co    = VAL_W'(r_connate_water) + VAL_W'(r_connate_oil);
    assign one_m_cw = ONE - VAL_W'(r_connate_water);
    assign prod_sw  = 27'(one_m_cw) * 27'(i_row_index);
    assign n_bad    = (cw_co >= ONE) || (r_row_count < 11'd2)
                   || (12'(r_row_count) > 12'(MAX_ROWS))
                   || (11'(i_row_index) >= r_row_count);
    assign n_last   = (11'(i_row_index) == (r_row_count - 11'd1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_band <= '0;
        end else if (adv) begin
            r_s1_band <= '{valid: i_valid, bad: n_bad, last: n_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_num <= 29'({prod_sw, 1'b0}) + 29'(r_row_count - 11'd1);
            r_s1_den <= {r_row_count - 11'd1, 1'b0};
        end
    end

    // saturation step: d = round(2*(ONE-cw)*i / 2*(n-1))
    logic [VAL_W-1:0] q_sw;
    t_band            band_a;

    crp_div #(.NUM_W(29), .DEN_W(12), .QUO_W(VAL_W)) u_div_sw (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_s1_num),
        .i_den (r_s1_den),
        .o_quo (q_sw)
    );

    crp_dly #(.W($bits(t_band)), .DEPTH(DIV_LAT)) u_dly_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_d     (r_s1_band),
        .o_q     (band_a)
    );

    // ------------------------------------------------------------------
    // stage 2: saturation, normalized numerators, capillary product
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] n_sw;
    logic [VAL_W:0]   sw_co;
    logic [VAL_W-1:0] oil_left;
    t_band            r_s2_band;
    logic [VAL_W-1:0] r_s2_sw;
    logic [33:0]      r_s2_num_w;
    logic [33:0]      r_s2_num_o;
    logic [32:0]      r_s2_gd;
    logic             r_s2_sat_w;
    logic             r_s2_zero_o;

    assign n_sw     = VAL_W'(r_connate_water) + q_sw;
    assign sw_co    = (VAL_W+1)'(n_sw) + (VAL_W+1)'(r_connate_oil);
    assign oil_left = ONE - n_sw - VAL_W'(r_connate_oil);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_band <= '0;
        end else if (adv) begin
            r_s2_band <= band_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_sw     <= n_sw;
            r_s2_num_w  <= (34'(q_sw) << FRAC_BITS) + 34'(denom >> 1);
            r_s2_num_o  <= (34'(oil_left) << FRAC_BITS) + 34'(denom >> 1);
            r_s2_gd     <= 33'(r_pressure_gain) * 33'(q_sw);
            r_s2_sat_w  <= (q_sw >= denom);
            r_s2_zero_o <= (sw_co >= (VAL_W+1)'(ONE));
        end
    end

    // normalized saturations
    logic [VAL_W-1:0] q_w;
    logic [VAL_W-1:0] q_o;
    logic [1:0]       flags_b;
    logic [52:0]      side_b;
    t_band            band_b;
    logic [VAL_W-1:0] sw_b;
    logic [32:0]      gd_b;

    crp_div #(.NUM_W(34), .DEN_W(VAL_W), .QUO_W(VAL_W)) u_div_w (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_s2_num_w),
        .i_den (denom),
        .o_quo (q_w)
    );

    crp_div #(.NUM_W(34), .DEN_W(VAL_W), .QUO_W(VAL_W)) u_div_o (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_s2_num_o),
        .i_den (denom),
        .o_quo (q_o)
    );

    crp_dly #(.W(2), .DEPTH(DIV_LAT)) u_dly_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_d     ({r_s2_sat_w, r_s2_zero_o}),
        .o_q     (flags_b)
    );

    crp_dly #(.W(53), .DEPTH(DIV_LAT + 1 + LOG_LAT)) u_dly_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_d     ({r_s2_band, r_s2_sw, r_s2_gd}),
        .o_q     (side_b)
    );

    assign {band_b, sw_b, gd_b} = side_b;

    // ------------------------------------------------------------------
    // stage 3: clamp normalized saturations
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] n_xw;
    logic [VAL_W-1:0] n_xo;
    logic [VAL_W-1:0] r_s3_xw;
    logic [VAL_W-1:0] r_s3_xo;
    logic [1:0]       r_s3_zero;

    assign n_xw = flags_b[1] ? ONE : q_w;
    assign n_xo = flags_b[0] ? '0 : q_o;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_xw   <= n_xw;
            r_s3_xo   <= n_xo;
            r_s3_zero <= {n_xw == '0, n_xo == '0};
        end
    end

    // -log2 of both bases
    logic [34:0] lw;
    logic [34:0] lo;
    logic [1:0]  zero_c;

    crp_log2 u_log_w (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_x    (r_s3_xw),
        .o_nlog (lw)
    );

    crp_log2 u_log_o (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_x    (r_s3_xo),
        .o_nlog (lo)
    );

    crp_dly #(.W(2), .DEPTH(LOG_LAT)) u_dly_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_d     (r_s3_zero),
        .o_q     (zero_c)
    );

    // ------------------------------------------------------------------
    // stage 4: exponent times log, capillary exponent
    // ------------------------------------------------------------------
    logic [50:0]      prod_tw;
    logic [50:0]      prod_to;
    logic [54:0]      prod_tpc;
    t_band            r_s4_band;
    logic [VAL_W-1:0] r_s4_sw;
    logic [1:0]       r_s4_zero;
    logic             r_s4_big_pc;
    logic [38:0]      r_s4_t_w;
    logic [38:0]      r_s4_t_o;
    logic [38:0]      r_s4_t_pc;

    assign prod_tw  = 51'(lw) * 51'(r_water_exponent);
    assign prod_to  = 51'(lo) * 51'(r_oil_exponent);
    assign prod_tpc = 55'(gd_b[29:0]) * 55'(L2E_Q24);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_band <= '0;
        end else if (adv) begin
            r_s4_band <= band_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s4_sw     <= sw_b;
            r_s4_zero   <= zero_c;
            r_s4_big_pc <= |gd_b[32:30];
            r_s4_t_w    <= prod_tw[50:12];
            r_s4_t_o    <= prod_to[50:12];
            r_s4_t_pc   <= 39'(prod_tpc[54:FRAC_BITS+2]);
        end
    end

    // 2^-t for the three terms
    logic [VAL_W-1:0] ex_w;
    logic [VAL_W-1:0] ex_o;
    logic [VAL_W-1:0] ex_pc;
    logic [22:0]      side_d;
    t_band            band_d;
    logic [VAL_W-1:0] sw_d;
    logic [1:0]       zero_d;
    logic             big_pc_d;

    crp_exp2 u_exp_w (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_t   (r_s4_t_w),
        .o_pow (ex_w)
    );

    crp_exp2 u_exp_o (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_t   (r_s4_t_o),
        .o_pow (ex_o)
    );

    crp_exp2 u_exp_pc (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_t   (r_s4_t_pc),
        .o_pow (ex_pc)
    );

    crp_dly #(.W(23), .DEPTH(EXP_LAT)) u_dly_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_d     ({r_s4_band, r_s4_sw, r_s4_zero, r_s4_big_pc}),
        .o_q     (side_d)
    );

    assign {band_d, sw_d, zero_d, big_pc_d} = side_d;

    // ------------------------------------------------------------------
    // stage 5: zero-base cases, endpoint scaling, output word
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] pw;
    logic [VAL_W-1:0] po;
    logic [VAL_W-1:0] sc_w;
    logic [VAL_W-1:0] sc_o;
    logic [33:0]      prod_rw;
    logic [33:0]      prod_ro;
    logic [VAL_W-1:0] rel_w;
    logic [VAL_W-1:0] rel_o;
    logic [VAL_W-1:0] pc;

    assign pw = zero_d[1] ? ((r_water_exponent != '0) ? '0 : ONE) : ex_w;
    assign po = zero_d[0] ? ((r_oil_exponent != '0) ? '0 : ONE) : ex_o;

    assign sc_w = (r_water_scale > ONE) ? ONE : r_water_scale;
    assign sc_o = (r_oil_scale > ONE) ? ONE : r_oil_scale;

    assign prod_rw = 34'(sc_w) * 34'(pw) + 34'(ONE >> 1);
    assign prod_ro = 34'(sc_o) * 34'(po) + 34'(ONE >> 1);
    assign rel_w   = VAL_W'(prod_rw >> FRAC_BITS);
    assign rel_o   = VAL_W'(prod_ro >> FRAC_BITS);
    assign pc      = big_pc_d ? '0 : ex_pc;

    logic [VAL_W-1:0] r_out_sw;
    logic [VAL_W-1:0] r_out_rw;
    logic [VAL_W-1:0] r_out_ro;
    logic [VAL_W-1:0] r_out_pc;
    logic             r_out_last;
    logic             r_out_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= band_d.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_sw   <= band_d.bad ? '0 : sw_d;
            r_out_rw   <= band_d.bad ? '0 : rel_w;
            r_out_ro   <= band_d.bad ? '0 : rel_o;
            r_out_pc   <= band_d.bad ? '0 : pc;
            r_out_last <= band_d.bad ? 1'b0 : band_d.last;
            r_out_bad  <= band_d.bad;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_water_saturation   = r_out_sw;
    assign o_water_relperm      = r_out_rw;
    assign o_oil_relperm        = r_out_ro;
    assign o_capillary_pressure = r_out_pc;
    assign o_last_row           = r_out_last;
    assign o_bad_setup          = r_out_bad;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_bad_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_setup) |-> (o_water_saturation == '0 && o_water_relperm == '0
            && o_oil_relperm == '0 && o_capillary_pressure == '0 && !o_last_row))
        else $error("bad setup word carries nonzero values");

    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_bad_setup) |-> (o_water_saturation <= ONE && o_water_relperm <= ONE
            && o_oil_relperm <= ONE && o_capillary_pressure <= ONE))
        else $error("result above one");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> ($stable(r_s1_band) && $stable(r_s4_band)))
        else $error("pipeline moved while output held");

endmodule

// ----- rtl/crp_dly.sv -----
// ----------------------------------------------------------------------------
// crp_dly
// Enabled delay line that keeps side data aligned with the arithmetic units.
// ----------------------------------------------------------------------------
module crp_dly #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_line [0:DEPTH-1];

    // shift one tap per advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DEPTH; s++) begin
                r_line[s] <= '0;
            end
        end else if (i_en) begin
            r_line[0] <= i_d;
            for (int s = 1; s < DEPTH; s++) begin
                r_line[s] <= r_line[s-1];
            end
        end
    end

    assign o_q = r_line[DEPTH-1];

endmodule

// ----- rtl/crp_div.sv -----
// ----------------------------------------------------------------------------
// crp_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees that the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module crp_div #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 12,
    parameter int QUO_W = 17
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    logic [DEN_W-1:0] r_rem [0:QUO_W-1];
    logic [QUO_W-1:0] r_low [0:QUO_W-1];
    logic [DEN_W-1:0] r_den [0:QUO_W-1];
    logic [QUO_W-1:0] r_q   [0:QUO_W-1];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [QUO_W-1:0] low_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] q_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             take;
        logic [DEN_W-1:0] n_rem;

        if (s == 0) begin : g_first
            // upper numerator bits seed the remainder
            assign rem_in = DEN_W'(i_num >> QUO_W);
            assign low_in = i_num[QUO_W-1:0];
            assign den_in = i_den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign low_in = r_low[s-1];
            assign den_in = r_den[s-1];
            assign q_in   = r_q[s-1];
        end

        // trial subtract of the shifted remainder
        assign trial = {rem_in, low_in[QUO_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign take  = (trial >= {1'b0, den_in});
        assign n_rem = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_low[s] <= low_in << 1;
                r_den[s] <= den_in;
                r_q[s]   <= {q_in[QUO_W-2:0], take};
            end
        end
    end

    assign o_quo = r_q[QUO_W-1];

endmodule

// ----- rtl/crp_log2.sv -----
// ----------------------------------------------------------------------------
// crp_log2
// Pipelined -log2(x/ONE) in Q.30: normalize, 30 squaring steps, combine.
// ----------------------------------------------------------------------------
module crp_log2
    import crp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [VAL_W-1:0] i_x,
    output logic [34:0]      o_nlog
);

    logic [30:0] r_m    [0:30];
    logic [29:0] r_frac [0:30];
    logic [4:0]  r_p    [0:30];
    logic [34:0] r_nlog;

    logic [4:0]  p;
    logic [47:0] sh;

    // leading one position
    always_comb begin
        p = '0;
        for (int b = 0; b < VAL_W; b++) begin
            if (i_x[b]) begin
                p = 5'(b);
            end
        end
    end

    assign sh = 48'(i_x) << (5'd30 - p);

    // normalize mantissa into [1, 2) in Q.30
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]    <= sh[30:0];
            r_frac[0] <= '0;
            r_p[0]    <= p;
        end
    end

    // one fraction bit per squaring step
    for (genvar k = 1; k <= 30; k++) begin : g_step
        logic [61:0] sq;
        logic [31:0] mm;
        logic [30:0] n_m;
        logic [29:0] n_frac;

        assign sq     = 62'(r_m[k-1]) * 62'(r_m[k-1]);
        assign mm     = sq[61:30];
        assign n_m    = mm[31] ? mm[31:1] : mm[30:0];
        assign n_frac = r_frac[k-1] | (mm[31] ? (30'd1 << (30 - k)) : 30'd0);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k]    <= n_m;
                r_frac[k] <= n_frac;
                r_p[k]    <= r_p[k-1];
            end
        end
    end

    // integer part from the leading one, less the fraction
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nlog <= {5'(FRAC_BITS) - r_p[30], 30'd0} - 35'(r_frac[30]);
        end
    end

    assign o_nlog = r_nlog;

endmodule

// ----- rtl/crp_exp2.sv -----
// ----------------------------------------------------------------------------
// crp_exp2
// Pipelined 2^-t for t in Q.30: product of root factors, then the integer
// part as a rounding shift into Q0.16.
// ----------------------------------------------------------------------------
module crp_exp2
    import crp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [38:0]      i_t,
    output logic [VAL_W-1:0] o_pow
);

    logic [8:0]       r_n   [0:30];
    logic [29:0]      r_f   [0:30];
    logic [30:0]      r_acc [0:30];
    logic [VAL_W-1:0] r_pow;

    // split integer and fraction
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]   <= i_t[38:30];
            r_f[0]   <= i_t[29:0];
            r_acc[0] <= 31'd1 << 30;
        end
    end

    // multiply in the factor of each set fraction bit, MSB first
    for (genvar k = 1; k <= 30; k++) begin : g_step
        localparam logic [29:0] FACTOR = root_factor(k);
        logic [60:0] prod;
        logic [30:0] n_acc;

        assign prod  = 61'(r_acc[k-1]) * 61'(FACTOR);
        assign n_acc = r_f[k-1][30-k] ? prod[60:30] : r_acc[k-1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k] <= n_acc;
                r_n[k]   <= r_n[k-1];
                r_f[k]   <= r_f[k-1];
            end
        end
    end

    // rounding shift by 14 plus the integer part; tiny results go to zero
    logic        big;
    logic [5:0]  shift;
    logic [55:0] rnd;
    logic [55:0] res;

    assign big   = (r_n[30] > 9'd40);
    assign shift = 6'(r_n[30][5:0]) + 6'd14;
    assign rnd   = 56'(r_acc[30]) + (56'd1 << (shift - 6'd1));
    assign res   = rnd >> shift;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pow <= big ? '0 : res[VAL_W-1:0];
        end
    end

    assign o_pow = r_pow;

endmodule
